// ----- hw/rtl/bdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, codes and constants shared by the byte deque modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int BDQ_DEPTH    = 32;
   localparam int BDQ_MODE_W   = 3;
   localparam int BDQ_KEY_W    = 8;
   localparam int BDQ_STATUS_W = 2;

   // Operation codes carried by the request mode field.
   typedef enum logic [BDQ_MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_DUMP       = 3'd4
   } bdq_mode_type;

   typedef enum logic [BDQ_STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } bdq_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_STREAM
   } bdq_state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_DUMP,
      OP_STREAM,
      OP_EMIT_FULL,
      OP_EMIT_EMPTY
   } bdq_op_type;

   typedef struct packed {
      logic       capture;
      bdq_op_type op;
   } bdq_cmd_type;

   typedef struct packed {
      logic [BDQ_MODE_W-1:0] mode;
      logic                  full;
      logic                  empty;
      logic                  walk_last;
   } bdq_stat_type;

endpackage : bdq_pkg
`default_nettype wire

// ----- hw/rtl/bdq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdq_ram
   import bdq_pkg::*;
#(
   parameter int WIDTH = BDQ_KEY_W,
   parameter int DEPTH = BDQ_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : bdq_ram
`default_nettype wire

// ----- hw/rtl/bdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller state machine: decodes the captured mode and sequences the
// datapath through execute and read-out steps.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire bdq_stat_type stat,
   output bdq_cmd_type       cmd
);

   bdq_state_type state_ff;
   bdq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((stat.mode inside {MODE_POP_FRONT, MODE_POP_BACK, MODE_DUMP})
                && !stat.empty) begin
               state_in = S_STREAM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_STREAM: begin
            if (stat.walk_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy        = 1'b1;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_EXEC: begin
            case (stat.mode)
               MODE_PUSH_FRONT: cmd.op = stat.full  ? OP_EMIT_FULL  : OP_PUSH_FRONT;
               MODE_PUSH_BACK:  cmd.op = stat.full  ? OP_EMIT_FULL  : OP_PUSH_BACK;
               MODE_POP_FRONT:  cmd.op = stat.empty ? OP_EMIT_EMPTY : OP_POP_FRONT;
               MODE_POP_BACK:   cmd.op = stat.empty ? OP_EMIT_EMPTY : OP_POP_BACK;
               MODE_DUMP:       cmd.op = stat.empty ? OP_EMIT_EMPTY : OP_DUMP;
               default:         cmd.op = OP_NONE;
            endcase
         end
         S_STREAM: begin
            cmd.op = OP_STREAM;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule : bdq_ctrl
`default_nettype wire

// ----- hw/rtl/bdq_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dpath
// Datapath: request registers, ring pointers, occupancy, walk counter,
// entry store and result registers.
// ----------------------------------------------------------------------------
module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [BDQ_MODE_W-1:0]   req_mode,
   input  wire logic [BDQ_KEY_W-1:0]    req_key,
   input  wire bdq_cmd_type             cmd,
   output bdq_stat_type                 stat,
   output logic                         rsp_strobe,
   output logic      [BDQ_KEY_W-1:0]    rsp_value,
   output logic      [BDQ_STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_MAX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_MAX : p - 1'b1;
   endfunction

   logic [BDQ_MODE_W-1:0]   mode_ff;
   logic [BDQ_KEY_W-1:0]    key_ff;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic [IDX_W-1:0]        walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]        walk_cnt_ff, walk_cnt_in;
   logic                    strobe_ff, strobe_in;
   logic [BDQ_KEY_W-1:0]    value_ff, value_in;
   logic [BDQ_STATUS_W-1:0] status_ff, status_in;
   logic                    last_ff, last_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [IDX_W-1:0]        rd_addr;
   logic [BDQ_KEY_W-1:0]    rd_data;

   bdq_ram #(
      .WIDTH (BDQ_KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in    = front_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      walk_ptr_in = walk_ptr_ff;
      walk_cnt_in = walk_cnt_ff;
      strobe_in   = 1'b0;
      value_in    = '0;
      status_in   = ST_OK;
      last_in     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      rd_addr     = front_ff;
      case (cmd.op)
         OP_PUSH_FRONT: begin
            wr_en    = 1'b1;
            wr_addr  = ring_dec(front_ff);
            front_in = ring_dec(front_ff);
            occ_in   = occ_ff + 1'b1;
         end
         OP_PUSH_BACK: begin
            wr_en   = 1'b1;
            wr_addr = tail_ff;
            tail_in = ring_inc(tail_ff);
            occ_in  = occ_ff + 1'b1;
         end
         OP_POP_FRONT: begin
            rd_addr     = front_ff;
            front_in    = ring_inc(front_ff);
            occ_in      = occ_ff - 1'b1;
            walk_cnt_in = CNT_W'(1);
         end
         OP_POP_BACK: begin
            rd_addr     = ring_dec(tail_ff);
            tail_in     = ring_dec(tail_ff);
            occ_in      = occ_ff - 1'b1;
            walk_cnt_in = CNT_W'(1);
         end
         OP_DUMP: begin
            rd_addr     = front_ff;
            walk_ptr_in = ring_inc(front_ff);
            walk_cnt_in = occ_ff;
         end
         OP_STREAM: begin
            // The word read last cycle goes out; the next read is issued.
            rd_addr     = walk_ptr_ff;
            walk_ptr_in = ring_inc(walk_ptr_ff);
            walk_cnt_in = walk_cnt_ff - 1'b1;
            strobe_in   = 1'b1;
            value_in    = rd_data;
            status_in   = ST_OK;
            last_in     = (walk_cnt_ff == CNT_W'(1));
         end
         OP_EMIT_FULL: begin
            strobe_in = 1'b1;
            status_in = ST_FULL;
            last_in   = 1'b1;
         end
         OP_EMIT_EMPTY: begin
            strobe_in = 1'b1;
            status_in = ST_EMPTY;
            last_in   = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         walk_ptr_ff <= '0;
         walk_cnt_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         front_ff    <= front_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         walk_ptr_ff <= walk_ptr_in;
         walk_cnt_ff <= walk_cnt_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign stat.mode      = mode_ff;
   assign stat.full      = (occ_ff == CNT_FULL);
   assign stat.empty     = (occ_ff == '0);
   assign stat.walk_last = (walk_cnt_ff == CNT_W'(1));

   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule : bdq_dpath
`default_nettype wire

// ----- hw/rtl/byte_deque.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// byte_deque
// Double-ended queue of bytes in a ring store, with push and pop at either
// end and a front-to-back dump of the whole contents.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                     Handshake
//   request   req_mode, req_key                         start high, busy low
//   result    rsp_value, rsp_status, rsp_last           rsp_strobe, one cycle
//
// A request passes from idle through the execute state. A push, an unused
// mode or an answer with a full or empty status then returns to idle; a pop,
// or a dump of a non-empty queue, goes on to a read-out state instead.
// That state is set by the single read port of the entry store, whose
// read data is registered, and the dump walks it one entry a cycle.
// Each result word appears on the result ports in the cycle after it is
// formed, for exactly one cycle; the receiver cannot stall the block.
// Reset is synchronous and active high and empties the queue; the entry
// store itself is not cleared.
//
module byte_deque
   import bdq_pkg::*;
#(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [BDQ_MODE_W-1:0]   req_mode,
   input  wire logic [BDQ_KEY_W-1:0]    req_key,
   output logic                         rsp_strobe,
   output logic      [BDQ_KEY_W-1:0]    rsp_value,
   output logic      [BDQ_STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);

   // Commands flow from the controller to the datapath, status back.
   bdq_cmd_type  cmd;
   bdq_stat_type stat;

   // The controller decodes the captured mode against the full and empty
   // flags and steps through execute and read-out states.
   bdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the ring pointers, occupancy, the entry store and
   // the result registers that part the block from the receiver.
   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   // A full status is only ever issued against a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT_FULL) |-> stat.full)
      else $error("full status issued while the queue has room");

   // Removing or dumping never starts on an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK || cmd.op == OP_DUMP)
      |-> !stat.empty)
      else $error("read issued on an empty queue");

   // Every result word stems from a command that forms one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.op == OP_STREAM || cmd.op == OP_EMIT_FULL
                           || cmd.op == OP_EMIT_EMPTY))
      else $error("result word without a command that forms it");

   // An accepted request keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

endmodule : byte_deque
`default_nettype wire

// ----- dv/tb_byte_deque.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_byte_deque
// Self-checking bench for the byte deque. Requests are sent over the
// start/busy handshake with random spacing, a shadow deque inside the bench
// predicts every result word, and each strobed word is checked field by
// field against the oldest prediction. Directed checks of the empty queue and
// of both ends come first, then a filling and draining run that also covers
// the full corner, then random phases that grow, shrink or churn the queue.
// ----------------------------------------------------------------------------
module tb_byte_deque;
   import bdq_pkg::*;

   localparam int DEPTH        = BDQ_DEPTH;
   // Generous bound: a full dump walks every stored entry, and the run sends
   // roughly a hundred and fifty requests with random gaps between them.
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_WORDS = 30;
   localparam int PRINT_LIMIT  = 40;

   // Mode codes that the block must ignore: no result and no state change.
   localparam logic [BDQ_MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [BDQ_MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   // One predicted result word.
   typedef struct packed {
      logic [BDQ_KEY_W-1:0] value;
      bdq_status_type       status;
      logic                 last;
   } answer_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [BDQ_MODE_W-1:0]   req_mode;
   logic [BDQ_KEY_W-1:0]    req_key;
   logic                    rsp_strobe;
   logic [BDQ_KEY_W-1:0]    rsp_value;
   logic [BDQ_STATUS_W-1:0] rsp_status;
   logic                    rsp_last;

   // Shadow copy of the deque: ring contents, front position and fill level.
   logic [BDQ_KEY_W-1:0] shadow_ring [DEPTH];
   int                   shadow_front;
   int                   shadow_count;

   // Result words still owed by the block, oldest first.
   answer_type pending_answers [$];

   int  error_count;
   int  cycle_count;
   // When clear, the sender keeps start high with no gaps between requests.
   bit  gaps_on;

   byte_deque #(
      .DEPTH      (BDQ_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop should the block hang or stop answering.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Every mismatch is counted; the printing is capped so that a badly
   // broken block cannot flood the log.
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   function automatic void owe_answer(input logic [BDQ_KEY_W-1:0] value,
                                      input bdq_status_type status,
                                      input logic last);
      answer_type word;
      word.value  = value;
      word.status = status;
      word.last   = last;
      pending_answers.push_back(word);
   endfunction

   // Applies one accepted request to the shadow deque and queues the words
   // that it must produce. Pushes are silent unless the queue is full; pops
   // and dumps on an empty queue give a single empty-status word.
   task automatic deque_predict(input logic [BDQ_MODE_W-1:0] mode,
                                input logic [BDQ_KEY_W-1:0]  key);
      int slot;
      int back;
      case (mode)
         MODE_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               owe_answer('0, ST_FULL, 1'b1);
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_front] = key;
               shadow_count++;
            end
         end
         MODE_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               owe_answer('0, ST_FULL, 1'b1);
            end else begin
               shadow_ring[(shadow_front + shadow_count) % DEPTH] = key;
               shadow_count++;
            end
         end
         MODE_POP_FRONT: begin
            if (shadow_count == 0) begin
               owe_answer('0, ST_EMPTY, 1'b1);
            end else begin
               owe_answer(shadow_ring[shadow_front], ST_OK, 1'b1);
               shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end
         end
         MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               owe_answer('0, ST_EMPTY, 1'b1);
            end else begin
               back = (shadow_front + shadow_count - 1) % DEPTH;
               owe_answer(shadow_ring[back], ST_OK, 1'b1);
               shadow_count--;
            end
         end
         MODE_DUMP: begin
            if (shadow_count == 0) begin
               owe_answer('0, ST_EMPTY, 1'b1);
            end else begin
               for (slot = 0; slot < shadow_count; slot++) begin
                  owe_answer(shadow_ring[(shadow_front + slot) % DEPTH], ST_OK,
                             slot == shadow_count - 1);
               end
            end
         end
         default: begin
            // Spare codes leave the deque untouched.
         end
      endcase
   endtask

   // Presents one request word and holds it until the block takes it. Start
   // is left high on return unless a gap is drawn, so that back-to-back
   // requests never lower and raise start within one time step.
   task automatic send_word(input logic [BDQ_MODE_W-1:0] mode,
                            input logic [BDQ_KEY_W-1:0]  key);
      int gap;
      req_mode <= mode;
      req_key  <= key;
      start    <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      deque_predict(mode, key);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending, waits for every owed word, then lets the block finish
   // any silent request still in flight.
   task automatic wait_for_quiet();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic [BDQ_KEY_W-1:0] random_key();
      return BDQ_KEY_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [BDQ_MODE_W-1:0] any_push();
      return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
   endfunction

   function automatic logic [BDQ_MODE_W-1:0] any_pop();
      return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
   endfunction

   // Straight after reset: pops and a dump find nothing, and the spare mode
   // codes are ignored.
   task automatic test_empty_queue();
      logic [BDQ_MODE_W-1:0] spare;
      gaps_on = 1'b1;
      send_word(MODE_POP_FRONT, 8'hFF);
      send_word(MODE_POP_BACK, 8'h00);
      send_word(MODE_DUMP, 8'hA5);
      for (spare = MODE_SPARE_FIRST; spare != MODE_SPARE_FIRST - 1; spare++) begin
         send_word(spare, 8'h5A);
         if (spare == MODE_SPARE_LAST) break;
      end
      send_word(MODE_POP_FRONT, 8'h3C);
      wait_for_quiet();
   endtask

   // Extreme and alternating bytes pushed at both ends, read back through a
   // dump and through pops from either end. Pushing at the front of an empty
   // queue wraps the front position round the ring.
   task automatic test_ends_and_keys();
      gaps_on = 1'b0;
      send_word(MODE_PUSH_FRONT, 8'h00);
      send_word(MODE_PUSH_BACK, 8'hFF);
      send_word(MODE_PUSH_FRONT, 8'h55);
      send_word(MODE_PUSH_BACK, 8'hAA);
      send_word(MODE_DUMP, 8'h00);
      gaps_on = 1'b1;
      send_word(MODE_POP_FRONT, 8'h00);
      send_word(MODE_POP_BACK, 8'h00);
      send_word(MODE_DUMP, 8'hFF);
      send_word(MODE_POP_BACK, 8'h00);
      send_word(MODE_POP_FRONT, 8'h00);
      send_word(MODE_POP_BACK, 8'h00);
      wait_for_quiet();
   endtask

   // Fills the ring with random bytes from random ends, checks that pushes
   // on a full queue are refused, dumps all of it, then drains it to empty.
   task automatic test_fill_and_drain();
      gaps_on = 1'($urandom_range(0, 1));
      while (shadow_count < DEPTH) send_word(any_push(), random_key());
      send_word(MODE_PUSH_FRONT, random_key());
      send_word(MODE_PUSH_BACK, random_key());
      send_word(MODE_DUMP, random_key());
      // Pause with the queue full before working it down again.
      wait_for_quiet();
      gaps_on = 1'b1;
      while (shadow_count > DEPTH / 2) send_word(any_pop(), random_key());
      while (shadow_count < DEPTH) send_word(any_push(), random_key());
      send_word(any_push(), random_key());
      gaps_on = 1'b0;
      while (shadow_count > 0) send_word(any_pop(), random_key());
      send_word(any_pop(), random_key());
      send_word(MODE_DUMP, random_key());
      wait_for_quiet();
   endtask

   // Random phases that mostly grow, mostly shrink or churn the queue, with
   // the occasional dump, a little noise from the spare codes, and now and
   // then a pause until everything owed has come back.
   task automatic test_random_traffic();
      int counted;
      int kind;
      int span;
      int pick;
      int push_share;
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         kind       = $urandom_range(0, 2);
         span       = $urandom_range(6, 16);
         gaps_on    = $urandom_range(0, 3) != 0;
         push_share = (kind == 0) ? 80 : (kind == 1) ? 20 : 50;
         repeat (span) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_word(BDQ_MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                         random_key());
            end else begin
               counted++;
               if (pick < 12) begin
                  send_word(MODE_DUMP, random_key());
               end else if ($urandom_range(0, 99) < push_share) begin
                  send_word(any_push(), random_key());
               end else begin
                  send_word(any_pop(), random_key());
               end
            end
         end
         if ($urandom_range(0, 5) == 0) wait_for_quiet();
      end
      wait_for_quiet();
   endtask

   // Every strobed word must match the oldest prediction. Outputs are
   // sampled at the clock edge, before the block updates them.
   always @(posedge clock) begin : result_check
      answer_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("word with nothing owed: value %h status %0d last %b",
                                      rsp_value, rsp_status, rsp_last));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_value !== want.value)
               report_mismatch($sformatf("value %h, expected %h", rsp_value, want.value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
         end
      end
   end

   initial begin
      error_count  = 0;
      shadow_front = 0;
      shadow_count = 0;
      gaps_on      = 1'b1;
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = MODE_PUSH_FRONT;
      req_key      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_ends_and_keys();
      test_fill_and_drain();
      test_random_traffic();

      // The last pause has already waited out the tail of the run; words
      // still owed here can only mean the block went quiet early.
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : tb_byte_deque
`default_nettype wire

// ----- filelist.f -----
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_dpath.sv
hw/rtl/byte_deque.sv
dv/tb_byte_deque.sv
